>>> rtl/aesd_pkg.sv
// shared types, substitution tables and field arithmetic for the aes-128 decrypt block
// no dependencies
`default_nettype none

package aesd_pkg;

    localparam int RoundKeys = 11;

    // configuration register indexes
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // command word from the controller to the datapath
    typedef struct packed {
        logic       load;       // latch ciphertext
        logic       exp_init;   // write round key 0 from the key registers
        logic       exp_step;   // derive round key key_idx from the previous one
        logic       rnd_add;    // initial key addition
        logic       rnd_mid;    // full inverse round
        logic       rnd_last;   // last inverse round, result out
        logic [3:0] key_idx;
    } t_cmd;

    localparam logic [2047:0] FWD_BOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_BOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        return FWD_BOX[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] x);
        return INV_BOX[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v   = x;
        for (int b = 0; b < 4; b++) begin
            if (y[b]) acc = acc ^ v;
            v = gf_double(v);
        end
        return acc;
    endfunction

    // byte k of the block sits at bits 127-8k downto 120-8k
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] =
                    inv_sub(s[127 - 8 * (((c - r) & 3) * 4 + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = gf_mul(a0, 4'hE) ^ gf_mul(a1, 4'hB)
                                 ^ gf_mul(a2, 4'hD) ^ gf_mul(a3, 4'h9);
            t[119 - 32 * c -: 8] = gf_mul(a0, 4'h9) ^ gf_mul(a1, 4'hE)
                                 ^ gf_mul(a2, 4'hB) ^ gf_mul(a3, 4'hD);
            t[111 - 32 * c -: 8] = gf_mul(a0, 4'hD) ^ gf_mul(a1, 4'h9)
                                 ^ gf_mul(a2, 4'hE) ^ gf_mul(a3, 4'hB);
            t[103 - 32 * c -: 8] = gf_mul(a0, 4'hB) ^ gf_mul(a1, 4'hD)
                                 ^ gf_mul(a2, 4'h9) ^ gf_mul(a3, 4'hE);
        end
        return t;
    endfunction

    // one step of the key schedule
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {fwd_sub(w3[23:16]) ^ rc, fwd_sub(w3[15:8]), fwd_sub(w3[7:0]),
              fwd_sub(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

>>> rtl/aesd_ctrl.sv
// sequencer for key expansion and the inverse rounds
// depends on aesd_pkg
`default_nettype none

module aesd_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire logic         i_cfg_we,
    output logic              busy,
    output aesd_pkg::t_cmd    o_cmd
);
    import aesd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXPAND = 2'd1;
    localparam logic [1:0] S_ROUND  = 2'd2;
    localparam logic [3:0] LastKey  = 4'(RoundKeys - 1);

    logic [1:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_keys_ready, n_keys_ready;
    t_cmd       cmd;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        cmd          = '0;
        cmd.key_idx  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) n_keys_ready = 1'b0;
                if (start) begin
                    cmd.load = 1'b1;
                    if (!r_keys_ready) begin
                        cmd.exp_init = 1'b1;
                        cmd.key_idx  = 4'd0;
                        n_state      = S_EXPAND;
                        n_cnt        = 4'd1;
                    end else begin
                        n_state = S_ROUND;
                        n_cnt   = LastKey;
                    end
                end
            end
            S_EXPAND: begin
                cmd.exp_step = 1'b1;
                if (r_cnt == LastKey) begin
                    n_keys_ready = 1'b1;
                    n_state      = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_ROUND: begin
                if (r_cnt == LastKey) cmd.rnd_add = 1'b1;
                else if (r_cnt == 4'd0) cmd.rnd_last = 1'b1;
                else cmd.rnd_mid = 1'b1;
                if (r_cnt == 4'd0) n_state = S_IDLE;
                else n_cnt = r_cnt - 4'd1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= 4'd0;
            r_keys_ready <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_keys_ready <= n_keys_ready;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

`ifndef ASSERT_OFF
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rnd_last |=> r_state == S_IDLE)
        else $error("last round not followed by idle");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_cnt <= LastKey)
        else $error("round counter out of range");
    a_expand_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXPAND |-> !r_keys_ready)
        else $error("expansion with keys marked ready");
`endif

endmodule

`default_nettype wire

>>> rtl/aesd_dp.sv
// key registers, round key store, key schedule and shared inverse round unit
// depends on aesd_pkg
`default_nettype none

module aesd_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire aesd_pkg::t_cmd i_cmd,
    input  wire logic           i_cfg_we,
    input  wire logic [0:0]     i_cfg_idx,
    input  wire logic [63:0]    i_cfg_data,
    input  wire logic [127:0]   i_cipher,
    output logic [127:0]        o_plain,
    output logic                o_valid
);
    import aesd_pkg::*;

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] r_rk [RoundKeys];
    logic [127:0] r_prev;
    logic [7:0]   r_rc;
    logic [127:0] r_state;
    logic [127:0] r_plain;
    logic         r_valid;
    logic [127:0] rk, shifted;

    assign rk      = r_rk[i_cmd.key_idx];
    assign shifted = inv_shift_sub(r_state) ^ rk;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end
    end

    // round key store and key schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_init) begin
            r_rk[i_cmd.key_idx] <= {r_key_high, r_key_low};
            r_prev              <= {r_key_high, r_key_low};
            r_rc                <= 8'h01;
        end else if (i_cmd.exp_step) begin
            r_rk[i_cmd.key_idx] <= next_round_key(r_prev, r_rc);
            r_prev              <= next_round_key(r_prev, r_rc);
            r_rc                <= gf_double(r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_state <= i_cipher;
        else if (i_cmd.rnd_add) r_state <= r_state ^ rk;
        else if (i_cmd.rnd_mid) r_state <= inv_mix(shifted);
        if (i_cmd.rnd_last) r_plain <= shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= i_cmd.rnd_last;
    end

    assign o_plain = r_plain;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> rtl/aes128_block_decrypt.sv
// top level of the aes-128 ecb block decryptor
// depends on aesd_pkg, aesd_ctrl and aesd_dp
`default_nettype none

// aes-128 block decryption, one 16-byte block per start pulse.
// a block is taken at a rising edge where start is high and busy is low.
// the ciphertext is latched at that edge. when the round keys are current
// one shared inverse-round unit then runs eleven times (key addition, nine
// full rounds, last round) while busy stays high; o_valid is registered
// from the last round, so it is shown when busy is low again.
// after reset or any key register write made while busy is low, the next
// block first runs the key schedule, one round key a cycle, then the rounds.
// o_valid is high for exactly one cycle with the plaintext on o_plain_*;
// there is no back-pressure, so the receiver must take each transfer.
// a new block may be started in the cycle o_valid is shown.
// key registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must write them only while busy is low, the block does not enforce
// it; index 0 is key bytes 0..7, index 1 is key bytes 8..15.
module aes128_block_decrypt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_cipher_high,
    input  wire logic [63:0] i_cipher_low,
    output logic             o_valid,
    output logic [63:0]      o_plain_high,
    output logic [63:0]      o_plain_low,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import aesd_pkg::*;

    t_cmd         cmd;
    logic [127:0] plain;

    // controller: sequencing and key freshness
    aesd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cfg_we (i_cfg_we),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // datapath: key store, schedule and round unit
    aesd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cipher   ({i_cipher_high, i_cipher_low}),
        .o_plain    (plain),
        .o_valid    (o_valid)
    );

    assign o_plain_high = plain[127:64];
    assign o_plain_low  = plain[63:0];

endmodule

`default_nettype wire
